// File: hw/rtl/cmd_pkg.sv
// Shared constants, configuration struct and sine table for the chorus delay.
package cmd_pkg;

    // Block geometry
    localparam int DELAY_DEPTH = 4096;
    localparam int SAMPLE_W    = 24;
    localparam int SINE_DEPTH  = 1024;
    localparam int FRAC_W      = 8;

    localparam int ADDR_W  = $clog2(DELAY_DEPTH);
    localparam int SINE_AW = $clog2(SINE_DEPTH);
    localparam int PHASE_W = 32;
    localparam int SINE_W  = 16;

    // Configuration register widths
    localparam int INC_W     = 31;
    localparam int CFG_DLY_W = 20;
    localparam int FB_W      = 16;
    localparam int MIX_W     = 17;

    localparam int FEEDBACK_MAX = 62259;
    localparam int MIX_MAX      = 65536;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_LFO_INC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 3'd4;

    // Register reset values
    localparam logic [INC_W-1:0]     LFO_INC_RST  = 31'd44739;
    localparam logic [CFG_DLY_W-1:0] CENTER_RST   = 20'd245760;
    localparam logic [CFG_DLY_W-1:0] DEPTH_RST    = 20'd61440;
    localparam logic [FB_W-1:0]      FEEDBACK_RST = 16'd0;
    localparam logic [MIX_W-1:0]     MIX_RST      = 17'd32768;

    // Settings handed from the register file to the core (gains already clamped)
    typedef struct packed {
        logic [INC_W-1:0]     lfo_inc;
        logic [CFG_DLY_W-1:0] center;
        logic [CFG_DLY_W-1:0] depth;
        logic [FB_W-1:0]      feedback;
        logic [MIX_W-1:0]     mix;
    } cmd_cfg_t;

    // Sine table, Q1.15, built at elaboration from the Q30 Taylor series
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

    function automatic logic signed [SINE_W-1:0] sine_q15(input int unsigned k);
        logic [63:0] k4;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic signed [SINE_W-1:0] mag;
        k4   = 64'(k) * 64'd4;
        quad = k4 / SINE_DEPTH;
        r    = k4 % SINE_DEPTH;
        if (quad[0]) begin
            r = 64'(SINE_DEPTH) - r;
        end
        x  = r * PI_HALF_Q30 / SINE_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        mag = SINE_W'(s);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            rom[i] = sine_q15(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// File: hw/rtl/chorus_modulated_delay.sv
// Chorus effect top level: configuration registers and the processing core.
//
// Usage:
//   s_valid/s_ready/s_sample_in carry one signed 24-bit input sample per
//   transaction; m_valid/m_ready/m_sample_out return one signed 24-bit output
//   sample per input, in order. cfg_valid/cfg_ready/cfg_index/cfg_data write
//   the five settings (index 0..4); other indexes are dropped. cfg_ready is
//   always high. Write settings only while no sample is in flight.
//   The sequencer takes no new sample until the last one has left its
//   final step; it runs six products through one shared multiplier and
//   two tap reads through the single read port of the delay RAM.
//   Reset (aresetn low, synchronous): settings return to their defaults, LFO
//   phase and write pointer go to zero, and the delay line reads as silence
//   until each entry is rewritten (tracked by a fill count, no clearing pass).
//   Output stall: the result sits in the output register while the next
//   sample is accepted and processed; that sample waits in its final step
//   until the output register is taken.
module chorus_modulated_delay (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [cmd_pkg::SAMPLE_W-1:0]    s_sample_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [cmd_pkg::SAMPLE_W-1:0]    m_sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cmd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [cmd_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import cmd_pkg::*;

    logic [INC_W-1:0]     lfo_inc_reg;
    logic [CFG_DLY_W-1:0] center_reg;
    logic [CFG_DLY_W-1:0] depth_reg;
    logic [FB_W-1:0]      feedback_reg;
    logic [MIX_W-1:0]     mix_reg;
    logic [FB_W-1:0]      fb_wr;
    logic [MIX_W-1:0]     mix_wr;
    cmd_cfg_t             cfg;

    assign cfg_ready = 1'b1;

    // Gains are clamped as they are written
    assign fb_wr  = cfg_data[FB_W-1:0];
    assign mix_wr = cfg_data[MIX_W-1:0];

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfo_inc_reg  <= LFO_INC_RST;
            center_reg   <= CENTER_RST;
            depth_reg    <= DEPTH_RST;
            feedback_reg <= FEEDBACK_RST;
            mix_reg      <= MIX_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LFO_INC:  lfo_inc_reg <= cfg_data[INC_W-1:0];
                REG_CENTER:   center_reg  <= cfg_data[CFG_DLY_W-1:0];
                REG_DEPTH:    depth_reg   <= cfg_data[CFG_DLY_W-1:0];
                REG_FEEDBACK: feedback_reg <= (fb_wr > FB_W'(FEEDBACK_MAX)) ?
                                              FB_W'(FEEDBACK_MAX) : fb_wr;
                REG_MIX:      mix_reg <= (mix_wr > MIX_W'(MIX_MAX)) ?
                                         MIX_W'(MIX_MAX) : mix_wr;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.lfo_inc  = lfo_inc_reg;
        cfg.center   = center_reg;
        cfg.depth    = depth_reg;
        cfg.feedback = feedback_reg;
        cfg.mix      = mix_reg;
    end

    cmd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    a_gain_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (feedback_reg <= FB_W'(FEEDBACK_MAX)) && (mix_reg <= MIX_W'(MIX_MAX)))
        else $error("gain register above its limit");

endmodule

// File: hw/rtl/cmd_sine_rom.sv
// Sine lookup ROM with a registered read port.
module cmd_sine_rom (
    input  logic                                 aclk,
    input  logic [cmd_pkg::SINE_AW-1:0]          addr,
    output logic signed [cmd_pkg::SINE_W-1:0]    q
);
    import cmd_pkg::*;

    // read data is registered
    always_ff @(posedge aclk) begin
        q <= SINE_ROM[addr];
    end

endmodule

// File: hw/rtl/cmd_delay_ram.sv
// Delay line storage: one write port, one registered read port.
module cmd_delay_ram (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [cmd_pkg::ADDR_W-1:0]           waddr,
    input  logic signed [cmd_pkg::SAMPLE_W-1:0]  wdata,
    input  logic [cmd_pkg::ADDR_W-1:0]           raddr,
    output logic signed [cmd_pkg::SAMPLE_W-1:0]  rdata
);
    import cmd_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/cmd_core.sv
// Chorus sequencer: LFO, delay computation, interpolated read, write-back, mix.
module cmd_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cmd_pkg::cmd_cfg_t                    cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cmd_pkg::SAMPLE_W-1:0]  s_sample_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cmd_pkg::SAMPLE_W-1:0]  m_sample_out
);
    import cmd_pkg::*;

    // Datapath widths
    localparam int MA_W       = SAMPLE_W;
    localparam int MB_W       = CFG_DLY_W + 1;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int DLY_W      = ADDR_W + FRAC_W;
    localparam int DSUM_W     = ((DLY_W > CFG_DLY_W) ? DLY_W : CFG_DLY_W) + 3;
    localparam int FILL_W     = ADDR_W + 1;
    localparam int LFO_SHIFT  = SINE_W - 1;
    localparam int GAIN_SHIFT = 16;

    localparam logic signed [ACC_W-1:0] HALF_LFO  = ACC_W'(1) << (LFO_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] HALF_FRAC = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] HALF_GAIN = ACC_W'(1) << (GAIN_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    localparam logic signed [DSUM_W-1:0] DLY_MIN_S = DSUM_W'(1) << FRAC_W;
    localparam logic signed [DSUM_W-1:0] DLY_MAX_S = DSUM_W'(DELAY_DEPTH - 2) << FRAC_W;
    localparam logic [DLY_W-1:0] DLY_MIN = DLY_W'(1) << FRAC_W;
    localparam logic [DLY_W-1:0] DLY_MAX = DLY_W'(DELAY_DEPTH - 2) << FRAC_W;
    localparam logic [FRAC_W:0]  FRAC_ONE = (FRAC_W + 1)'(1) << FRAC_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DELAY_DEPTH);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_SINE = 12'b0000_0000_0010,
        ST_DLY  = 12'b0000_0000_0100,
        ST_ADDR = 12'b0000_0000_1000,
        ST_RD0  = 12'b0000_0001_0000,
        ST_RD1  = 12'b0000_0010_0000,
        ST_WET  = 12'b0000_0100_0000,
        ST_FB   = 12'b0000_1000_0000,
        ST_DRY  = 12'b0001_0000_0000,
        ST_WR   = 12'b0010_0000_0000,
        ST_SUM  = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } state_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        if (v > SAT_HI) begin
            return SAMPLE_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            return SAMPLE_W'(SAT_LO);
        end
        return SAMPLE_W'(v);
    endfunction

    state_t state_reg, state_next;

    logic [PHASE_W-1:0]         phase_reg;
    logic [ADDR_W-1:0]          wr_idx_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_data_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] wet_reg;
    logic signed [SAMPLE_W-1:0] stored_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [DLY_W-1:0]           delay_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [ADDR_W-1:0]          i1_reg;
    logic                       v0_reg;
    logic                       v1_reg;

    logic                       accept;
    logic                       out_free;
    logic signed [SINE_W-1:0]   sine_q;
    logic signed [SAMPLE_W-1:0] ram_q;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       ram_we;

    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    dly_rnd;
    logic signed [DSUM_W-1:0]   dly_sum;
    logic [DLY_W-1:0]           dly_clamped;
    logic [ADDR_W-1:0]          whole;
    logic [ADDR_W-1:0]          i0;
    logic                       v0;
    logic                       v1;
    logic signed [ACC_W-1:0]    interp_rnd;
    logic signed [ACC_W-1:0]    fb_rnd;
    logic signed [ACC_W-1:0]    stored_sum;
    logic signed [ACC_W-1:0]    mix_rnd;
    logic [MIX_W-1:0]           dry_gain;

    assign accept       = s_valid && s_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

    // Memories
    cmd_sine_rom u_sine_rom (
        .aclk (aclk),
        .addr (phase_reg[PHASE_W-1 -: SINE_AW]),
        .q    (sine_q)
    );

    assign ram_we  = (state_reg == ST_WR);
    assign rd_addr = (state_reg == ST_ADDR) ? i0 : i1_reg;

    cmd_delay_ram u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (stored_reg),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Delay in fractional samples, clamped to the usable span of the line
    assign prod_ext = ACC_W'(prod_reg);
    assign dly_rnd  = (prod_ext + HALF_LFO) >>> LFO_SHIFT;
    assign dly_sum  = DSUM_W'(dly_rnd) + DSUM_W'(signed'({1'b0, cfg.center}));

    always_comb begin
        priority if (dly_sum < DLY_MIN_S) begin
            dly_clamped = DLY_MIN;
        end else if (dly_sum > DLY_MAX_S) begin
            dly_clamped = DLY_MAX;
        end else begin
            dly_clamped = DLY_W'(dly_sum);
        end
    end

    // Tap addresses; a tap older than the samples written so far reads as zero
    assign whole = delay_reg[DLY_W-1:FRAC_W];
    assign i0    = wr_idx_reg - whole;
    assign v0    = (FILL_W'(whole) <= fill_reg);
    assign v1    = ((FILL_W'(whole) + FILL_W'(1)) <= fill_reg);

    // Rounded scalings of the accumulated products
    assign interp_rnd = (acc_reg + prod_ext + HALF_FRAC) >>> FRAC_W;
    assign fb_rnd     = (prod_ext + HALF_GAIN) >>> GAIN_SHIFT;
    assign stored_sum = ACC_W'(x_reg) + fb_rnd;
    assign mix_rnd    = (acc_reg + prod_ext + HALF_GAIN) >>> GAIN_SHIFT;
    assign dry_gain   = MIX_W'(MIX_MAX) - cfg.mix;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SINE: begin
                mul_a = MA_W'(sine_q);
                mul_b = MB_W'(cfg.depth);
            end
            ST_RD0: begin
                mul_a = v0_reg ? ram_q : '0;
                mul_b = MB_W'(FRAC_ONE - {1'b0, frac_reg});
            end
            ST_RD1: begin
                mul_a = v1_reg ? ram_q : '0;
                mul_b = MB_W'(frac_reg);
            end
            ST_FB: begin
                mul_a = wet_reg;
                mul_b = MB_W'(cfg.feedback);
            end
            ST_DRY: begin
                mul_a = x_reg;
                mul_b = MB_W'(dry_gain);
            end
            ST_WR: begin
                mul_a = wet_reg;
                mul_b = MB_W'(cfg.mix);
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SINE;
            ST_SINE: state_next = ST_DLY;
            ST_DLY:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_RD0;
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_WET;
            ST_WET:  state_next = ST_FB;
            ST_FB:   state_next = ST_DRY;
            ST_DRY:  state_next = ST_WR;
            ST_WR:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            wr_idx_reg  <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                phase_reg <= phase_reg + PHASE_W'(cfg.lfo_inc);
            end
            if (ram_we) begin
                wr_idx_reg <= wr_idx_reg + ADDR_W'(1);
                if (fill_reg != FILL_MAX) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= result_reg;
        end
        unique case (state_reg)
            ST_IDLE: if (accept) x_reg <= s_sample_in;
            ST_DLY:  delay_reg <= dly_clamped;
            ST_ADDR: begin
                frac_reg <= delay_reg[FRAC_W-1:0];
                i1_reg   <= i0 - ADDR_W'(1);
                v0_reg   <= v0;
                v1_reg   <= v1;
            end
            ST_RD1:  acc_reg <= prod_ext;
            ST_WET:  wet_reg <= SAMPLE_W'(interp_rnd);
            ST_DRY:  stored_reg <= sat_sample(stored_sum);
            ST_WR:   acc_reg <= prod_ext;
            ST_SUM:  result_reg <= sat_sample(mix_rnd);
            default: begin
            end
        endcase
    end

    // Checks
    a_rd_not_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADDR) |-> (i0 != wr_idx_reg))
        else $error("tap read aliases the write entry");

    a_delay_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADDR) |-> (delay_reg >= DLY_MIN && delay_reg <= DLY_MAX))
        else $error("delay outside clamp range");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count overran the line depth");

    a_wr_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (wr_idx_reg == ADDR_W'($past(wr_idx_reg) + ADDR_W'(1))))
        else $error("write pointer did not advance after a write");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule
